// File: rtl/core/lec_pkg.sv
// Shared constants and types for the 3x3 local extremum counter.
package lec_pkg;

    // Configuration port layout
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

    // Position of a sample inside its frame, reduced to what the window needs
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic row_last;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } t_pos;

endpackage

// File: rtl/core/lec_if.sv
// Handshake channels of the 3x3 local extremum counter: samples, counts, configuration.
interface lec_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lec_count_if #(
    parameter int CNT_W = 21
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] extremum_count;

    modport source (output valid, output extremum_count, input ready);
    modport sink   (input valid, input extremum_count, output ready);
endinterface

interface lec_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lec_pkg::CFG_IDX_W-1:0]    index;
    logic [lec_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/local_extremum_counter_3x3.sv
// Top level: streaming 3x3 strict local extremum counter with two line buffers.
//
//  channel    dir  payload                         request moves
//  i_sample   in   sample [SAMPLE_BITS] signed     one frame element, raster order
//  o_result   out  extremum_count [CNT_W]          count of one finished frame
//  i_cfg      in   index [1], data [11]            frame_rows (0) / frame_cols (1)
//
//  One sample per cycle unless a stalled result holds the read stage. A sample
//  waits in the read stage (line buffer read data registered) and is judged as
//  it leaves; the last sample of a frame then loads the result register, which
//  offers the count. Reset clears positions, count, sizes (1x1) and all valid
//  flags; line buffers are not cleared. A stalled result only holds the read
//  stage when it carries the last sample of the next frame; otherwise samples
//  keep flowing. Configuration is always ready and restarts the frame.
module local_extremum_counter_3x3 #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lec_cfg_if.sink            i_cfg,
    lec_sample_if.sink         i_sample,
    lec_count_if.source        o_result
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RSZ_W = $clog2(MAX_ROWS + 1);
    localparam int CSZ_W = $clog2(MAX_COLS + 1);
    localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef t_smp t_win [3][3];

    // ------------------------------------------------------------------
    // Judge one window cell: strictly above or strictly below every
    // neighbor that lies in the frame. No neighbors at all counts too.
    // ------------------------------------------------------------------
    function automatic logic judge(input t_win w, input int cr, input int cc,
                                   input logic [2:0] rok, input logic [2:0] cok);
        logic gt;
        logic lt;
        t_smp x;
        gt = 1'b1;
        lt = 1'b1;
        x  = w[cr][cc];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == cr && j == cc) && rok[i] && cok[j]) begin
                    if (!(x > w[i][j])) gt = 1'b0;
                    if (!(x < w[i][j])) lt = 1'b0;
                end
            end
        end
        return gt | lt;
    endfunction

    // ------------------------------------------------------------------
    // Configuration: clamp sizes on write, restart the frame
    // ------------------------------------------------------------------
    logic [RSZ_W-1:0] r_rows;
    logic [CSZ_W-1:0] r_cols;
    logic [RSZ_W-1:0] rows_wr;
    logic [CSZ_W-1:0] cols_wr;
    logic             cfg_acc;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid & i_cfg.ready;

    always_comb begin
        if (i_cfg.data == '0) begin
            rows_wr = RSZ_W'(1);
            cols_wr = CSZ_W'(1);
        end else begin
            rows_wr = (32'(i_cfg.data) > 32'(MAX_ROWS)) ? RSZ_W'(MAX_ROWS)
                                                       : RSZ_W'(i_cfg.data);
            cols_wr = (32'(i_cfg.data) > 32'(MAX_COLS)) ? CSZ_W'(MAX_COLS)
                                                       : CSZ_W'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RSZ_W'(1);
            r_cols <= CSZ_W'(1);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                lec_pkg::REG_FRAME_ROWS: r_rows <= rows_wr;
                lec_pkg::REG_FRAME_COLS: r_cols <= cols_wr;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic         r_a_vld;
    t_smp         r_a_smp;
    lec_pkg::t_pos r_a_pos;
    logic         a_last;
    logic         a_go;
    logic         in_acc;
    logic         r_out_vld;
    logic [CNT_W-1:0] r_out_cnt;

    assign a_last         = r_a_pos.row_last & r_a_pos.col_last;
    assign a_go           = r_a_vld & (~a_last | ~r_out_vld | o_result.ready);
    assign i_sample.ready = ~r_a_vld | a_go;
    assign in_acc         = i_sample.valid & i_sample.ready;

    // ------------------------------------------------------------------
    // Frame position of the next sample
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    lec_pkg::t_pos    pos;

    always_comb begin
        pos.row_ge1  = 32'(r_row) >= 32'd1;
        pos.row_ge2  = 32'(r_row) >= 32'd2;
        pos.row_last = (32'(r_row) + 32'd1) == 32'(r_rows);
        pos.col_ge1  = 32'(r_col) >= 32'd1;
        pos.col_ge2  = 32'(r_col) >= 32'd2;
        pos.col_last = (32'(r_col) + 32'd1) == 32'(r_cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_acc) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if (pos.col_last) begin
                r_col <= '0;
                r_row <= pos.row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffers. newer holds the row above, older the row above that.
    // newer is rewritten with the sample at accept time; older takes the
    // displaced newer value in the next cycle from the registered read data,
    // with a bypass when the next read hits the same column.
    // ------------------------------------------------------------------
    t_smp mem_older [MAX_COLS];
    t_smp mem_newer [MAX_COLS];
    t_smp r_rd_older;
    t_smp r_rd_newer;
    t_smp r_byp_data;
    logic r_byp;
    logic r_pw_vld;
    logic [COL_W-1:0] r_pw_addr;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_older       <= mem_older[r_col];
            r_rd_newer       <= mem_newer[r_col];
            mem_newer[r_col] <= i_sample.sample;
        end
        if (r_pw_vld) begin
            mem_older[r_pw_addr] <= r_rd_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byp_data <= r_rd_newer;
            r_pw_addr  <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            r_pw_vld <= in_acc;
            if (in_acc) begin
                r_byp <= r_pw_vld && (r_pw_addr == r_col);
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage: sample and its position flags wait beside the read data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_smp <= i_sample.sample;
            r_a_pos <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_go) begin
            r_a_vld <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window: rows top/upper/bottom = r-2/r-1/r, columns c-2/c-1/c.
    // The two left columns are registers; the right column is live.
    // ------------------------------------------------------------------
    t_smp r_wl [3];
    t_smp r_wm [3];
    t_win win;
    t_smp older_eff;

    assign older_eff = r_byp ? r_byp_data : r_rd_older;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win[k][0] = r_wl[k];
            win[k][1] = r_wm[k];
        end
        win[0][2] = older_eff;
        win[1][2] = r_rd_newer;
        win[2][2] = r_a_smp;
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            for (int k = 0; k < 3; k++) begin
                r_wl[k] <= r_wm[k];
            end
            r_wm[0] <= older_eff;
            r_wm[1] <= r_rd_newer;
            r_wm[2] <= r_a_smp;
        end
    end

    // ------------------------------------------------------------------
    // Judge up to four cells per sample:
    //   upper row, middle column  - always once both exist
    //   upper row, right column   - at row end (right edge cell)
    //   bottom row, middle column - on the last row (no row below)
    //   bottom row, right column  - last sample of the frame
    // ------------------------------------------------------------------
    logic [3:0] hit;
    logic [2:0] hit_sum;

    always_comb begin
        hit[0] = r_a_pos.row_ge1 & r_a_pos.col_ge1 &
                 judge(win, 1, 1, {1'b1, 1'b1, r_a_pos.row_ge2},
                                  {1'b1, 1'b1, r_a_pos.col_ge2});
        hit[1] = r_a_pos.row_ge1 & r_a_pos.col_last &
                 judge(win, 1, 2, {1'b1, 1'b1, r_a_pos.row_ge2},
                                  {1'b1, r_a_pos.col_ge1, 1'b0});
        hit[2] = r_a_pos.row_last & r_a_pos.col_ge1 &
                 judge(win, 2, 1, {1'b1, r_a_pos.row_ge1, 1'b0},
                                  {1'b1, 1'b1, r_a_pos.col_ge2});
        hit[3] = a_last &
                 judge(win, 2, 2, {1'b1, r_a_pos.row_ge1, 1'b0},
                                  {1'b1, r_a_pos.col_ge1, 1'b0});
        hit_sum = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
    end

    // ------------------------------------------------------------------
    // Running count and result register
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign n_count = r_count + CNT_W'(hit_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_acc) begin
            r_count <= '0;
        end else if (a_go) begin
            r_count <= a_last ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (a_go && a_last) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && a_last) begin
            r_out_cnt <= n_count;
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.extremum_count = r_out_cnt;

endmodule
